@@ rtl/lbc_pkg.sv @@
// Shared types, constants and decode function of the lever backlight controller.
`default_nettype none
package lbc_pkg;

    // Debounce history.
    localparam int HISTORY_DEPTH = 10;
    localparam int SLOT_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    // Field widths.
    localparam int SAMPLE_W = 8;
    localparam int PINS_W   = 3;
    localparam int TICKS_W  = 16;
    localparam int DUTY_W   = 8;
    localparam int SEL_W    = 5;
    localparam int DVS_W    = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Register reset values.
    localparam logic [7:0]  MIN_SUPPLY_RST = 8'd95;
    localparam logic [7:0]  NIGHT_BL_RST   = 8'd100;
    localparam logic [7:0]  NIGHT_LV_RST   = 8'd30;
    localparam logic [7:0]  DAY_BL_RST     = 8'd50;
    localparam logic [7:0]  DAY_LV_RST     = 8'd150;
    localparam logic [15:0] MIN_PERIOD_RST = 16'd10000;

    // Duty reported for an unusable measurement.
    localparam logic [7:0] DUTY_INVALID = 8'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_SUPPLY = 3'd0,
        CFG_NIGHT_BL   = 3'd1,
        CFG_NIGHT_LV   = 3'd2,
        CFG_DAY_BL     = 3'd3,
        CFG_DAY_LV     = 3'd4,
        CFG_MIN_PERIOD = 3'd5
    } cfg_index_t;

    // Lever pin patterns.
    localparam logic [PINS_W-1:0] PAT_P = 3'd4;
    localparam logic [PINS_W-1:0] PAT_R = 3'd6;
    localparam logic [PINS_W-1:0] PAT_N = 3'd7;
    localparam logic [PINS_W-1:0] PAT_D = 3'd3;
    localparam logic [PINS_W-1:0] PAT_M = 3'd1;

    // One-hot lever LED codes.
    localparam logic [SEL_W-1:0] SEL_P    = 5'b10000;
    localparam logic [SEL_W-1:0] SEL_R    = 5'b01000;
    localparam logic [SEL_W-1:0] SEL_N    = 5'b00100;
    localparam logic [SEL_W-1:0] SEL_D    = 5'b00010;
    localparam logic [SEL_W-1:0] SEL_M    = 5'b00001;
    localparam logic [SEL_W-1:0] SEL_NONE = 5'b00000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RATIO_GO,
        S_RATIO_WAIT,
        S_GAIN_GO,
        S_GAIN_WAIT,
        S_DUTY_GO,
        S_DUTY_WAIT,
        S_BL_GO,
        S_BL_WAIT,
        S_LV_GO,
        S_LV_WAIT,
        S_OUT
    } state_t;

    function automatic logic [SEL_W-1:0] decode_lever(input logic [PINS_W-1:0] pat);
        logic [SEL_W-1:0] sel;
        case (pat)
            PAT_P:   sel = SEL_P;
            PAT_R:   sel = SEL_R;
            PAT_N:   sel = SEL_N;
            PAT_D:   sel = SEL_D;
            PAT_M:   sel = SEL_M;
            default: sel = SEL_NONE;
        endcase
        return sel;
    endfunction

endpackage
`default_nettype wire

@@ rtl/lbc_debounce.sv @@
// Lever pin history, settle detection and one-hot decode of the stable pattern.
`default_nettype none
module lbc_debounce (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       sample,
    input  wire logic [lbc_pkg::PINS_W-1:0] pins,
    output logic      [lbc_pkg::SEL_W-1:0]  lever_select
);

    logic [lbc_pkg::PINS_W-1:0] hist_reg [lbc_pkg::HISTORY_DEPTH];
    logic [lbc_pkg::SLOT_W-1:0] slot_reg;
    logic [lbc_pkg::SLOT_W-1:0] slot_next;
    logic [lbc_pkg::PINS_W-1:0] stable_reg;
    logic [lbc_pkg::PINS_W-1:0] stable_next;
    logic                       settled;

    always_comb begin
        settled = 1'b1;
        for (int i = 1; i < lbc_pkg::HISTORY_DEPTH; i++) begin
            if (hist_reg[i] != hist_reg[0]) begin
                settled = 1'b0;
            end
        end
        stable_next = settled ? hist_reg[0] : stable_reg;
        if (slot_reg == lbc_pkg::SLOT_W'(lbc_pkg::HISTORY_DEPTH - 1)) begin
            slot_next = '0;
        end else begin
            slot_next = slot_reg + lbc_pkg::SLOT_W'(1);
        end
    end

    // The history only changes on a new sample, so following it every cycle
    // gives the same stable pattern as checking once after each write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < lbc_pkg::HISTORY_DEPTH; i++) begin
                hist_reg[i] <= '0;
            end
            slot_reg   <= '0;
            stable_reg <= '0;
        end else begin
            stable_reg <= stable_next;
            if (sample) begin
                hist_reg[slot_reg] <= pins;
                slot_reg           <= slot_next;
            end
        end
    end

    assign lever_select = lbc_pkg::decode_lever(stable_reg);

endmodule
`default_nettype wire

@@ rtl/lbc_divider.sv @@
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module lbc_divider (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [lbc_pkg::TICKS_W-1:0] dividend,
    input  wire logic [lbc_pkg::DVS_W-1:0]   divisor,
    output logic                             done,
    output logic      [lbc_pkg::TICKS_W-1:0] quotient
);

    localparam int CNT_W = $clog2(lbc_pkg::TICKS_W);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [lbc_pkg::TICKS_W-1:0] qd_reg;
    logic [lbc_pkg::DVS_W-1:0]   rem_reg;
    logic [lbc_pkg::DVS_W-1:0]   dvs_reg;
    logic [lbc_pkg::DVS_W:0]     trial;
    logic [lbc_pkg::DVS_W:0]     diff;
    logic                        fits;

    // Shifted partial remainder against the divisor; a zero divisor always
    // fits, which yields an all-ones quotient.
    always_comb begin
        trial = {rem_reg, qd_reg[lbc_pkg::TICKS_W-1]};
        fits  = (trial >= {1'b0, dvs_reg});
        diff  = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(lbc_pkg::TICKS_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            qd_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            qd_reg  <= {qd_reg[lbc_pkg::TICKS_W-2:0], fits};
            rem_reg <= fits ? diff[lbc_pkg::DVS_W-1:0] : trial[lbc_pkg::DVS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = qd_reg;

endmodule
`default_nettype wire

@@ rtl/lbc_multiplier.sv @@
// Shift-and-add multiplier that takes one multiplier bit per cycle.
`default_nettype none
module lbc_multiplier (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [lbc_pkg::DUTY_W-1:0] mcand,
    input  wire logic [lbc_pkg::DUTY_W-1:0] mplier,
    output logic                            done,
    output logic      [2*lbc_pkg::DUTY_W-1:0] product
);

    localparam int W     = lbc_pkg::DUTY_W;
    localparam int CNT_W = $clog2(W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     mcand_reg;
    logic [2*W-1:0]   prod_reg;
    logic [W:0]       sum;

    // Upper half sums; lower half holds low product and unused multiplier bits.
    assign sum = {1'b0, prod_reg[2*W-1:W]} + (prod_reg[0] ? {1'b0, mcand_reg} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg <= mcand;
            prod_reg  <= {{W{1'b0}}, mplier};
        end else if (busy_reg) begin
            prod_reg <= {sum, prod_reg[W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule
`default_nettype wire

@@ rtl/lever_backlight_controller.sv @@
// Top level of the lever backlight controller: sequencer, registers and stream ports.
`default_nettype none
// Channel   Direction  Bits  Contents
// s_        in         72+3  supply samples, lever pins, PWM times; PWM flags in tuser
// m_        out        40+1  duties, lever LED, input duty, gain; lever fault in tuser
// cfg_      in         3+16  register index and write data, write on cfg_we
//
// One word is taken at a time; the next one can be taken in the cycle after a result is loaded.
// The result is loaded after the gain ratio division and gain multiplication for an invalid lever
// pattern, after the two duty scalings as well otherwise, and after a PWM duty division before
// those when a measurement is divided: the divider and the multiplier are shared and bit-serial.
// Reset is synchronous and active low, loads all register defaults and holds s_tready low.
// A stalled result waits in the output register while the next word is already accepted.
module lever_backlight_controller (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: supply_sample_a[7:0], supply_sample_b[15:8], supply_sample_c[23:16],
    // supply_sample_d[31:24], lever_pins[34:32], pwm_high_ticks[50:35],
    // pwm_low_ticks[66:51], zero fill [71:67]
    input  wire logic [71:0] s_tdata,
    // s_tuser: pwm_always_high[0], pwm_always_low[1], pwm_measured_ok[2]
    input  wire logic [2:0]  s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // m_tdata: backlight_duty_out[7:0], lever_duty_out[15:8], lever_select[20:16],
    // input_duty[28:21], supply_gain[36:29], zero fill [39:37]
    output logic      [39:0] m_tdata,
    // m_tuser: lever_fault[0]
    output logic      [0:0]  m_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        cfg_we,
    input  wire logic [lbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lbc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration registers.
    logic [7:0]  min_supply_reg;
    logic [7:0]  night_bl_reg;
    logic [7:0]  night_lv_reg;
    logic [7:0]  day_bl_reg;
    logic [7:0]  day_lv_reg;
    logic [15:0] min_period_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_supply_reg <= lbc_pkg::MIN_SUPPLY_RST;
            night_bl_reg   <= lbc_pkg::NIGHT_BL_RST;
            night_lv_reg   <= lbc_pkg::NIGHT_LV_RST;
            day_bl_reg     <= lbc_pkg::DAY_BL_RST;
            day_lv_reg     <= lbc_pkg::DAY_LV_RST;
            min_period_reg <= lbc_pkg::MIN_PERIOD_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                lbc_pkg::CFG_MIN_SUPPLY: min_supply_reg <= cfg_wdata[7:0];
                lbc_pkg::CFG_NIGHT_BL:   night_bl_reg   <= cfg_wdata[7:0];
                lbc_pkg::CFG_NIGHT_LV:   night_lv_reg   <= cfg_wdata[7:0];
                lbc_pkg::CFG_DAY_BL:     day_bl_reg     <= cfg_wdata[7:0];
                lbc_pkg::CFG_DAY_LV:     day_lv_reg     <= cfg_wdata[7:0];
                lbc_pkg::CFG_MIN_PERIOD: min_period_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    lbc_pkg::state_t state_reg;
    lbc_pkg::state_t state_next;

    logic s_accept;
    // No word is taken while reset is applied.
    assign s_tready = aresetn && (state_reg == lbc_pkg::S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // The supply average is formed and clamped as the word is taken; the period
    // sum is registered too so that the validity checks start from registers.
    logic [9:0]  supply_sum;
    logic [7:0]  supply_avg;
    logic [7:0]  avg_clamped;
    logic [15:0] period_in;

    always_comb begin
        supply_sum  = {2'b00, s_tdata[7:0]} + {2'b00, s_tdata[15:8]}
                    + {2'b00, s_tdata[23:16]} + {2'b00, s_tdata[31:24]};
        supply_avg  = supply_sum[9:2];
        avg_clamped = (supply_avg < min_supply_reg) ? min_supply_reg : supply_avg;
        period_in   = s_tdata[50:35] + s_tdata[66:51];
    end

    logic [7:0]  avg_reg;
    logic [15:0] high_reg;
    logic [15:0] period_reg;
    logic        always_high_reg;
    logic        always_low_reg;
    logic        measured_ok_reg;
    logic [7:0]  ratio_reg;
    logic [7:0]  gain_reg;
    logic [7:0]  bl_reg;
    logic [7:0]  lv_reg;
    logic [7:0]  held_duty_reg;
    logic [39:0] m_tdata_reg;
    logic        m_fault_reg;
    logic        m_tvalid_reg;

    logic [lbc_pkg::SEL_W-1:0] lever_select;

    lbc_debounce u_debounce (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .sample       (s_accept),
        .pins         (s_tdata[34:32]),
        .lever_select (lever_select)
    );

    // Shared divider: first the gain ratio, then the PWM duty.
    logic        div_start;
    logic        div_done;
    logic [15:0] div_dividend;
    logic [8:0]  div_divisor;
    logic [15:0] div_quot;
    logic [8:0]  duty_divisor;

    lbc_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Shared multiplier: the ratio squared into the gain, then the two duty scalings.
    logic        mul_start;
    logic        mul_done;
    logic [7:0]  mul_a;
    logic [7:0]  mul_b;
    logic [15:0] mul_prod;

    lbc_multiplier u_multiplier (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (mul_a),
        .mplier  (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    logic use_day_duty;
    logic measure;
    logic duty_invalid;
    logic out_free;

    always_comb begin
        // Divisor is the period over 256, rounded on the low byte.
        duty_divisor = {1'b0, period_reg[15:8]} + {8'b0, period_reg[7]};
        duty_invalid = (high_reg == '0) || (period_reg == '0) || (high_reg >= period_reg)
                    || (period_reg < min_period_reg) || (duty_divisor == '0);
        use_day_duty = !always_high_reg && always_low_reg;
        measure      = !always_high_reg && !always_low_reg && measured_ok_reg;
        out_free     = !m_tvalid_reg || m_tready;
    end

    always_comb begin
        state_next   = state_reg;
        div_start    = 1'b0;
        mul_start    = 1'b0;
        div_dividend = {min_supply_reg, 8'h00};
        div_divisor  = {1'b0, avg_reg};
        mul_a        = ratio_reg;
        mul_b        = ratio_reg;
        case (state_reg)
            lbc_pkg::S_IDLE: begin
                if (s_accept) begin
                    state_next = lbc_pkg::S_RATIO_GO;
                end
            end
            lbc_pkg::S_RATIO_GO: begin
                div_start  = 1'b1;
                state_next = lbc_pkg::S_RATIO_WAIT;
            end
            lbc_pkg::S_RATIO_WAIT: begin
                if (div_done) begin
                    state_next = lbc_pkg::S_GAIN_GO;
                end
            end
            lbc_pkg::S_GAIN_GO: begin
                mul_start  = 1'b1;
                state_next = lbc_pkg::S_GAIN_WAIT;
            end
            lbc_pkg::S_GAIN_WAIT: begin
                if (mul_done) begin
                    if (lever_select == lbc_pkg::SEL_NONE) begin
                        state_next = lbc_pkg::S_OUT;
                    end else if (measure && !duty_invalid) begin
                        state_next = lbc_pkg::S_DUTY_GO;
                    end else begin
                        state_next = lbc_pkg::S_BL_GO;
                    end
                end
            end
            lbc_pkg::S_DUTY_GO: begin
                div_start    = 1'b1;
                div_dividend = high_reg;
                div_divisor  = duty_divisor;
                state_next   = lbc_pkg::S_DUTY_WAIT;
            end
            lbc_pkg::S_DUTY_WAIT: begin
                if (div_done) begin
                    state_next = lbc_pkg::S_BL_GO;
                end
            end
            lbc_pkg::S_BL_GO: begin
                mul_start  = 1'b1;
                mul_a      = use_day_duty ? day_bl_reg : night_bl_reg;
                mul_b      = gain_reg;
                state_next = lbc_pkg::S_BL_WAIT;
            end
            lbc_pkg::S_BL_WAIT: begin
                if (mul_done) begin
                    state_next = lbc_pkg::S_LV_GO;
                end
            end
            lbc_pkg::S_LV_GO: begin
                mul_start  = 1'b1;
                mul_a      = use_day_duty ? day_lv_reg : night_lv_reg;
                mul_b      = gain_reg;
                state_next = lbc_pkg::S_LV_WAIT;
            end
            lbc_pkg::S_LV_WAIT: begin
                if (mul_done) begin
                    state_next = lbc_pkg::S_OUT;
                end
            end
            lbc_pkg::S_OUT: begin
                if (out_free) begin
                    state_next = lbc_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = lbc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lbc_pkg::S_IDLE;
            held_duty_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == lbc_pkg::S_GAIN_WAIT && mul_done
                    && lever_select != lbc_pkg::SEL_NONE && measure && duty_invalid) begin
                held_duty_reg <= lbc_pkg::DUTY_INVALID;
            end else if (state_reg == lbc_pkg::S_DUTY_WAIT && div_done) begin
                held_duty_reg <= div_quot[7:0];
            end
            if (state_reg == lbc_pkg::S_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            avg_reg         <= avg_clamped;
            high_reg        <= s_tdata[50:35];
            period_reg      <= period_in;
            always_high_reg <= s_tuser[0];
            always_low_reg  <= s_tuser[1];
            measured_ok_reg <= s_tuser[2];
            bl_reg          <= '0;
            lv_reg          <= '0;
        end
        if (state_reg == lbc_pkg::S_RATIO_WAIT && div_done) begin
            // The ratio saturates at full scale.
            ratio_reg <= (div_quot[15:8] != '0) ? 8'hFF : div_quot[7:0];
        end
        if (state_reg == lbc_pkg::S_GAIN_WAIT && mul_done) begin
            gain_reg <= mul_prod[15:8];
        end
        if (state_reg == lbc_pkg::S_BL_WAIT && mul_done) begin
            bl_reg <= mul_prod[15:8];
        end
        if (state_reg == lbc_pkg::S_LV_WAIT && mul_done) begin
            lv_reg <= mul_prod[15:8];
        end
        if (state_reg == lbc_pkg::S_OUT && out_free) begin
            m_tdata_reg <= {3'b000, gain_reg, held_duty_reg, lever_select, lv_reg, bl_reg};
            m_fault_reg <= (lever_select == lbc_pkg::SEL_NONE);
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_fault_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule
`default_nettype wire
